// File: src/ljfs_pkg.sv
// Package for the longest-job-first selection core.
// Holds field widths, default parameter values, state and code types.
// No dependencies.
package ljfs_pkg;

   localparam int DEF_READY_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 16;

   localparam int PID_W   = 8;
   localparam int REM_W   = 16;
   localparam int STATE_W = 2;
   localparam int KIND_W  = 2;

   typedef enum logic [STATE_W-1:0] {
      EXIT_READY    = 2'd0,
      EXIT_BLOCKED  = 2'd1,
      EXIT_FINISHED = 2'd2,
      EXIT_INVALID  = 2'd3
   } exit_state_type;

   typedef enum logic [KIND_W-1:0] {
      RETIRE_NONE     = 2'd0,
      RETIRE_BLOCKED  = 2'd1,
      RETIRE_FINISHED = 2'd2
   } retire_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } fsm_state_type;

endpackage

// File: src/ljfs_ram.sv
// Ready store memory: one write port, one read port, registered read data.
// No dependencies.
module ljfs_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/longest_job_first_select_core.sv
// Longest-job-first selection core: ready store, scan for largest remaining time.
// Depends on ljfs_pkg and ljfs_ram.
//
//   channel | ports       | direction | moves
//   --------+-------------+-----------+-------------------------------------
//   request | req_*       | in        | handed-back process (scheduler call)
//   result  | rsp_*       | out       | selected process, retire/error flags
//
// Steps: a request is accepted (and a ready process inserted), the store is
//   scanned from the oldest entry, the gap left by the chosen slot is closed
//   by moving each later entry down one, and the result is loaded; an empty
//   store skips the scan and gap close. The single read port of the store,
//   walked one entry per cycle, paces the scan and the gap close.
// Reset: clears the entry count and all control state; no memory sweep.
// Stalls: a finished result waits in the output register while the next
//   request is taken; the core only holds in its final step if that register
//   is still full.
module longest_job_first_select_core #(
   parameter int READY_DEPTH = ljfs_pkg::DEF_READY_DEPTH,
   parameter int TIME_BITS   = ljfs_pkg::DEF_TIME_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_has_current,
   input  logic [ljfs_pkg::PID_W-1:0]   req_current_pid,
   input  logic [ljfs_pkg::REM_W-1:0]   req_current_remaining,
   input  logic [ljfs_pkg::STATE_W-1:0] req_current_state,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_selected_valid,
   output logic [ljfs_pkg::PID_W-1:0]   rsp_selected_pid,
   output logic [ljfs_pkg::REM_W-1:0]   rsp_selected_remaining,
   output logic [ljfs_pkg::KIND_W-1:0]  rsp_retired_kind,
   output logic                         rsp_bad_state,
   output logic                         rsp_ready_overflow
);
   import ljfs_pkg::*;

   localparam int IDX_W   = $clog2(READY_DEPTH);
   localparam int CNT_W   = $clog2(READY_DEPTH + 1);
   localparam int ENTRY_W = PID_W + TIME_BITS;
   localparam int EXT_W   = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;

   fsm_state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic                 rdv_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 found_ff;
   logic [PID_W-1:0]     best_pid_ff;
   logic [TIME_BITS-1:0] best_time_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   retire_type           retired_ff;
   logic                 bad_ff;
   logic                 ovf_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_sel_valid_ff;
   logic [PID_W-1:0]     rsp_pid_ff;
   logic [REM_W-1:0]     rsp_rem_ff;
   retire_type           rsp_kind_ff;
   logic                 rsp_bad_ff;
   logic                 rsp_ovf_ff;

   logic                 accept;
   logic                 full;
   logic                 insert;
   logic [CNT_W-1:0]     count_after;
   logic                 issue;
   logic                 scan_exit;
   logic                 shift_exit;
   logic                 load;
   logic                 shift_wr;
   retire_type           kind_in;
   logic                 bad_in;
   logic                 ovf_in;

   logic [EXT_W-1:0]     rem_ext;
   logic [TIME_BITS-1:0] rem_stored;
   logic [EXT_W-1:0]     best_ext;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [ENTRY_W-1:0]   mem_wdata;
   logic [ENTRY_W-1:0]   mem_rdata;
   logic [PID_W-1:0]     rd_pid;
   logic [TIME_BITS-1:0] rd_time;

   // Request decode: classify the handed-back process.
   always_comb begin
      kind_in = RETIRE_NONE;
      bad_in  = 1'b0;
      ovf_in  = 1'b0;
      insert  = 1'b0;
      if (req_has_current) begin
         unique case (exit_state_type'(req_current_state))
            EXIT_READY: begin
               insert = !full;
               ovf_in = full;
            end
            EXIT_BLOCKED:  kind_in = RETIRE_BLOCKED;
            EXIT_FINISHED: kind_in = RETIRE_FINISHED;
            EXIT_INVALID:  bad_in  = 1'b1;
         endcase
      end
   end

   assign accept      = req_valid && req_ready;
   assign full        = (count_ff == CNT_W'(READY_DEPTH));
   assign count_after = count_ff + CNT_W'(accept && insert);

   // Fit the 16-bit time field to the stored width, and back for the result.
   assign rem_ext    = EXT_W'(req_current_remaining);
   assign rem_stored = rem_ext[TIME_BITS-1:0];
   assign best_ext   = EXT_W'(best_time_ff);

   // Walk the store one read a cycle, in both the scan and the gap close.
   assign issue      = (state_ff == ST_SCAN || state_ff == ST_SHIFT) && (idx_ff < count_ff);
   assign scan_exit  = (state_ff == ST_SCAN) && !issue && !rdv_ff;
   assign shift_exit = (state_ff == ST_SHIFT) && !issue && !rdv_ff;
   assign load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign shift_wr   = (state_ff == ST_SHIFT) && rdv_ff;

   assign rd_pid  = mem_rdata[ENTRY_W-1:TIME_BITS];
   assign rd_time = mem_rdata[TIME_BITS-1:0];

   // Append on an accepted insert; during the gap close move each later entry down one.
   assign mem_we    = (accept && insert) || shift_wr;
   assign mem_waddr = shift_wr ? (rd_idx_ff - IDX_W'(1)) : count_ff[IDX_W-1:0];
   assign mem_wdata = shift_wr ? mem_rdata : {req_current_pid, rem_stored};

   ljfs_ram #(
      .DEPTH (READY_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (count_after == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_exit) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (shift_exit) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready              = (state_ff == ST_IDLE);
      rsp_valid              = rsp_valid_ff;
      rsp_selected_valid     = rsp_sel_valid_ff;
      rsp_selected_pid       = rsp_pid_ff;
      rsp_selected_remaining = rsp_rem_ff;
      rsp_retired_kind       = rsp_kind_ff;
      rsp_bad_state          = rsp_bad_ff;
      rsp_ready_overflow     = rsp_ovf_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= issue;

         // Count: grow on insert, shrink once the gap is closed.
         if (accept) begin
            count_ff <= count_after;
         end else if (shift_exit) begin
            count_ff <= count_ff - CNT_W'(1);
         end

         // Read pointer: scan from the oldest, then close from past the winner.
         if (accept) begin
            idx_ff <= '0;
         end else if (scan_exit) begin
            idx_ff <= CNT_W'(best_idx_ff) + CNT_W'(1);
         end else if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end

         // Strict compare keeps the oldest entry on a tie.
         if (accept) begin
            found_ff <= 1'b0;
         end else if (state_ff == ST_SCAN && rdv_ff) begin
            found_ff <= 1'b1;
         end

         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[IDX_W-1:0];
      if (accept) begin
         retired_ff <= kind_in;
         bad_ff     <= bad_in;
         ovf_ff     <= ovf_in;
      end
      if (state_ff == ST_SCAN && rdv_ff && (!found_ff || rd_time > best_time_ff)) begin
         best_pid_ff  <= rd_pid;
         best_time_ff <= rd_time;
         best_idx_ff  <= rd_idx_ff;
      end
      if (load) begin
         rsp_sel_valid_ff <= found_ff;
         rsp_pid_ff       <= found_ff ? best_pid_ff : '0;
         rsp_rem_ff       <= found_ff ? best_ext[REM_W-1:0] : '0;
         rsp_kind_ff      <= retired_ff;
         rsp_bad_ff       <= bad_ff;
         rsp_ovf_ff       <= ovf_ff;
      end
   end

   // Checks.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(READY_DEPTH))
      else $error("ready count exceeds store depth");

   a_read_in_walk : assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (state_ff == ST_SCAN || state_ff == ST_SHIFT))
      else $error("read data returned outside scan or gap close");

   a_shift_target : assert property (@(posedge clock) disable iff (reset)
      shift_wr |-> (rd_idx_ff != '0))
      else $error("gap close moved the oldest entry");

   a_done_found : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (found_ff || count_ff == '0))
      else $error("nonempty store finished without a selection");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("loaded result not presented");

endmodule
